// File: rtl/core/shift_subtract_divider_defines.svh
`ifndef SHIFT_SUBTRACT_DIVIDER_DEFINES_SVH
`define SHIFT_SUBTRACT_DIVIDER_DEFINES_SVH

// same-cycle implication under synchronous reset
`define SSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous reset
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ssd_pkg.sv
package ssd_pkg;

    typedef enum logic [1:0] {
        KIND_UQUO = 2'd0,
        KIND_UREM = 2'd1,
        KIND_SQUO = 2'd2,
        KIND_SREM = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_SUB,
        ST_FIX
    } t_state;

    typedef struct packed {
        logic load;
        logic norm;
        logic sub;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic norm_done;
        logic sub_done;
    } t_dp_sts;

endpackage

// File: rtl/core/ssd_req_if.sv
interface ssd_req_if
    import ssd_pkg::*;
#(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    t_kind            kind;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    modport source (output valid, kind, dividend, divisor, input ready);
    modport sink (input valid, kind, dividend, divisor, output ready);
endinterface

// File: rtl/core/ssd_rsp_if.sv
interface ssd_rsp_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result;

    modport source (output valid, result, input ready);
    modport sink (input valid, result, output ready);
endinterface

// File: rtl/core/ssd_ctrl.sv
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_NORM;
                end
            end
            ST_NORM: begin
                if (i_sts.norm_done) begin
                    n_state = ST_SUB;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            ST_SUB: begin
                if (i_sts.sub_done) begin
                    n_state = ST_FIX;
                end else begin
                    o_cmd.sub = 1'b1;
                end
            end
            ST_FIX: begin
                // output register free or being drained this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/ssd_dpath.sv
module ssd_dpath
    import ssd_pkg::*;
#(
    parameter int WIDTH = 32
)(
    input  logic             i_clk,
    input  t_dp_cmd          i_cmd,
    input  t_kind            i_kind,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output t_dp_sts          o_sts,
    output logic [WIDTH-1:0] o_result
);

    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_bit;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_result;
    logic             r_neg_q;
    logic             r_neg_r;
    logic             r_is_rem;

    logic             is_signed;
    logic             neg_a;
    logic             neg_b;
    logic [WIDTH-1:0] mag_a;
    logic [WIDTH-1:0] mag_b;
    logic             fits;
    logic [WIDTH-1:0] fix_val;

    assign is_signed = (i_kind == KIND_SQUO) || (i_kind == KIND_SREM);
    assign neg_a     = is_signed && i_dividend[WIDTH-1];
    assign neg_b     = is_signed && i_divisor[WIDTH-1];
    assign mag_a     = neg_a ? (~i_dividend + 1'b1) : i_dividend;
    assign mag_b     = neg_b ? (~i_divisor + 1'b1) : i_divisor;

    assign fits = (r_num >= r_den);

    assign o_sts.norm_done = !((r_den < r_num) && (r_bit != '0) && !r_den[WIDTH-1]);
    assign o_sts.sub_done  = (r_bit == '0);

    always_comb begin
        if (r_is_rem) begin
            fix_val = r_neg_r ? (~r_num + 1'b1) : r_num;
        end else begin
            fix_val = r_neg_q ? (~r_quo + 1'b1) : r_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num    <= mag_a;
            r_den    <= mag_b;
            r_bit    <= {{(WIDTH-1){1'b0}}, 1'b1};
            r_quo    <= '0;
            r_neg_q  <= neg_a ^ neg_b;
            r_neg_r  <= neg_a;
            r_is_rem <= (i_kind == KIND_UREM) || (i_kind == KIND_SREM);
        end else if (i_cmd.norm) begin
            r_den <= {r_den[WIDTH-2:0], 1'b0};
            r_bit <= {r_bit[WIDTH-2:0], 1'b0};
        end else if (i_cmd.sub) begin
            if (fits) begin
                r_num <= r_num - r_den;
                r_quo <= r_quo | r_bit;
            end
            r_den <= {1'b0, r_den[WIDTH-1:1]};
            r_bit <= {1'b0, r_bit[WIDTH-1:1]};
        end
        if (i_cmd.finish) begin
            r_result <= fix_val;
        end
    end

    assign o_result = r_result;

endmodule

// File: rtl/core/shift_subtract_divider.sv
// sequence: accept, then s divisor normalization shifts, then t subtract steps (t = s + 1,
//   or 0 when a zero divisor meets a nonzero dividend), then the fix-up into the output
//   register; one shared subtractor does one bit per cycle; a stalled result holds the
//   last step
// throughput: one transaction in flight; the next request is taken once the result is
//   in the output register, even while that result still waits
// reset: synchronous active-low i_rst_n returns the controller to idle, output invalid
module shift_subtract_divider
    import ssd_pkg::*;
#(
    parameter int WIDTH = 32
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssd_req_if.sink     i_req,
    ssd_rsp_if.source   o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ssd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ssd_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_kind     (i_req.kind),
        .i_dividend (i_req.dividend),
        .i_divisor  (i_req.divisor),
        .o_sts      (sts),
        .o_result   (o_rsp.result)
    );

endmodule

// File: rtl/core/ssd_checker.sv
`include "shift_subtract_divider_defines.svh"

module ssd_checker #(
    parameter int WIDTH = 32
)(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [WIDTH-1:0] i_out_result
);

    `SSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result valid dropped while stalled")
    `SSD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_result), "result changed while stalled")
    `SSD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready && !$rose(i_out_valid), "request taken while busy or result too early")
    `SSD_ASSERT_NOW(a_idle_on_result, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready, "not ready for a request after result")

endmodule

bind shift_subtract_divider ssd_checker #(
    .WIDTH (WIDTH)
) u_ssd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_result (o_rsp.result)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ssd_pkg::*;

    localparam int WIDTH        = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 825;
    localparam int PHASES       = 3;

    typedef struct {
        t_kind            kind;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] result;
    } t_div_txn;

    class div_scoreboard;
        t_div_txn pending_results[$];
        int       fail_count;
        int       checked_count;

        function new();
            fail_count    = 0;
            checked_count = 0;
        endfunction

        static function logic [WIDTH-1:0] divide_expected(t_kind k, logic [WIDTH-1:0] a,
                                                           logic [WIDTH-1:0] b);
            logic             is_signed;
            logic             neg_a;
            logic             neg_b;
            logic [WIDTH-1:0] num;
            logic [WIDTH-1:0] den;
            logic [WIDTH-1:0] bitm;
            logic [WIDTH-1:0] quo;
            logic [WIDTH-1:0] res;
            is_signed = (k == KIND_SQUO) || (k == KIND_SREM);
            neg_a     = is_signed && a[WIDTH-1];
            neg_b     = is_signed && b[WIDTH-1];
            num       = neg_a ? -a : a;
            den       = neg_b ? -b : b;
            bitm      = 1;
            quo       = '0;
            // normalize the divisor
            while (den < num && bitm != 0 && !den[WIDTH-1]) begin
                den  = den << 1;
                bitm = bitm << 1;
            end
            // restoring subtraction
            while (bitm != 0) begin
                if (num >= den) begin
                    num = num - den;
                    quo = quo | bitm;
                end
                bitm = bitm >> 1;
                den  = den >> 1;
            end
            case (k)
                KIND_UQUO: res = quo;
                KIND_UREM: res = num;
                KIND_SQUO: res = (neg_a != neg_b) ? -quo : quo;
                default:   res = neg_a ? -num : num;
            endcase
            return res;
        endfunction

        function void note_request(t_kind k, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
            t_div_txn t;
            t.kind     = k;
            t.dividend = a;
            t.divisor  = b;
            t.result   = divide_expected(k, a, b);
            pending_results.push_back(t);
        endfunction

        function void check_result(logic [WIDTH-1:0] actual);
            t_div_txn t;
            if (pending_results.size() == 0) begin
                $error("result: unexpected transaction, expected none actual %h", actual);
                fail_count++;
                return;
            end
            t = pending_results.pop_front();
            checked_count++;
            if (actual !== t.result) begin
                $error("result (%s %h / %h): expected %h actual %h", t.kind.name(),
                       t.dividend, t.divisor, t.result, actual);
                fail_count++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssd_req_if #(.WIDTH(WIDTH)) req_bus ();
    ssd_rsp_if #(.WIDTH(WIDTH)) rsp_bus ();

    shift_subtract_divider #(.WIDTH(WIDTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    div_scoreboard sb = new();

    int send_idle_pct = 17;
    int recv_idle_pct = 88;
    int stall_cycles  = 0;
    int sent_count    = 0;

    logic [WIDTH-1:0] dir_dividend [6] = '{32'h0000_0000, 32'h1234_5678, 32'h8000_0000,
                                           32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFF9};
    logic [WIDTH-1:0] dir_divisor  [6] = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                                           32'h0000_0001, 32'h8000_0000, 32'h0000_0002};

    always #4 i_clk = ~i_clk;

    // response side and result checking
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready)
                sb.check_result(rsp_bus.result);
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [WIDTH-1:0] rand_operand();
        logic [WIDTH-1:0] v;
        case ($urandom_range(7))
            0: v = $urandom_range(15);
            1: v = -$urandom_range(1, 15);
            2: begin
                case ($urandom_range(4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            3: v = $urandom >> $urandom_range(31);
            4: v = -($urandom >> $urandom_range(31));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_request(t_kind k, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.kind     <= k;
        req_bus.dividend <= a;
        req_bus.divisor  <= b;
        do
            @(posedge i_clk);
        while (!req_bus.ready);
        sb.note_request(k, a, b);
        sent_count++;
    endtask

    initial begin
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        req_bus.valid    <= 1'b0;
        req_bus.kind     <= KIND_UQUO;
        req_bus.dividend <= '0;
        req_bus.divisor  <= '0;
        i_rst_n          <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, division by zero, most negative dividend
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 4; k++)
                send_request(t_kind'(k), dir_dividend[i], dir_divisor[i]);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (RANDOM_ITEMS / PHASES) begin
                a = rand_operand();
                b = rand_operand();
                if ($urandom_range(3) == 0)
                    b = b >> $urandom_range(WIDTH - 1);
                send_request(t_kind'($urandom_range(3)), a, b);
            end
        end
        req_bus.valid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * WIDTH + 8) @(posedge i_clk);

        $display("sent %0d requests over all four kinds, %0d results checked,",
                 sent_count, sb.checked_count);
        $display("with sender and receiver stalls in both directions and a stall-free phase");
        if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ssd_pkg.sv
rtl/core/ssd_req_if.sv
rtl/core/ssd_rsp_if.sv
rtl/core/ssd_ctrl.sv
rtl/core/ssd_dpath.sv
rtl/core/shift_subtract_divider.sv
rtl/core/ssd_checker.sv
test/tb_top.sv
